@@ hdl/sle_pkg.sv @@
`default_nettype none

package sle_pkg;

    // Default list depth
    localparam int DEPTH_DEF = 16;

    // Width that holds any index, position or count for the widest list supported
    localparam int IDX_W  = 11;
    localparam int DATA_W = 32;
    localparam int OPC_W  = 2;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int FIDX_W = 4;
    localparam int CNT_W  = 5;

    // Operation codes
    typedef enum logic [OPC_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_GET    = 2'd2,
        OP_LOCATE = 2'd3
    } t_opcode;

    // Status codes
    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd4;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_START,
        S_SCAN,
        S_FINISH
    } t_state;

    // Command broadcast to every cell
    typedef struct packed {
        logic                     commit;
        t_opcode                  op;
        logic [IDX_W-1:0]         pos;
        logic [IDX_W-1:0]         count;
        logic signed [DATA_W-1:0] value;
    } t_cmd;

    // Probe record handed from cell to cell
    typedef struct packed {
        logic                     tok;
        logic                     hit;
        logic signed [DATA_W-1:0] data;
        logic [IDX_W-1:0]         idx;
    } t_probe;

endpackage

`default_nettype wire

@@ hdl/sle_in_if.sv @@
`default_nettype none

interface sle_in_if;
    logic                                 valid;
    logic                                 ready;
    logic [sle_pkg::OPC_W-1:0]            opcode;
    logic [sle_pkg::POS_W-1:0]            position;
    logic signed [sle_pkg::DATA_W-1:0]    value;

    modport source (output valid, output opcode, output position, output value, input ready);
    modport sink   (input valid, input opcode, input position, input value, output ready);
endinterface

`default_nettype wire

@@ hdl/sle_out_if.sv @@
`default_nettype none

interface sle_out_if;
    logic                                 valid;
    logic                                 ready;
    logic [sle_pkg::STAT_W-1:0]           status;
    logic signed [sle_pkg::DATA_W-1:0]    data_out;
    logic [sle_pkg::FIDX_W-1:0]           found_index;
    logic [sle_pkg::CNT_W-1:0]            count;

    modport source (output valid, output status, output data_out, output found_index,
                    output count, input ready);
    modport sink   (input valid, input status, input data_out, input found_index,
                    input count, output ready);
endinterface

`default_nettype wire

@@ hdl/sle_cell.sv @@
`default_nettype none

module sle_cell #(
    parameter int INDEX = 0
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire sle_pkg::t_cmd                  i_cmd,
    input  wire logic signed [sle_pkg::DATA_W-1:0] i_left,
    input  wire logic signed [sle_pkg::DATA_W-1:0] i_right,
    input  wire sle_pkg::t_probe                i_probe,
    output logic signed [sle_pkg::DATA_W-1:0]   o_entry,
    output sle_pkg::t_probe                     o_probe
);

    // Fixed 0-based index and 1-based position of this cell
    localparam logic [sle_pkg::IDX_W-1:0] C_IDX = sle_pkg::IDX_W'(INDEX);
    localparam logic [sle_pkg::IDX_W-1:0] C_POS = sle_pkg::IDX_W'(INDEX + 1);

    logic signed [sle_pkg::DATA_W-1:0] r_entry;
    logic signed [sle_pkg::DATA_W-1:0] n_entry;
    sle_pkg::t_probe                   r_probe;
    sle_pkg::t_probe                   n_probe;
    logic                              w_match;

    // Decide whether this cell answers the probe
    always_comb begin
        case (i_cmd.op)
            sle_pkg::OP_LOCATE: w_match = (C_IDX < i_cmd.count) && (r_entry == i_cmd.value);
            sle_pkg::OP_GET,
            sle_pkg::OP_DELETE: w_match = (C_POS == i_cmd.pos);
            default:            w_match = 1'b0;
        endcase
    end

    // Pass the probe on, claiming it on the first match
    always_comb begin
        n_probe = i_probe;
        if (i_probe.tok && !i_probe.hit && w_match) begin
            n_probe.hit  = 1'b1;
            n_probe.data = r_entry;
            n_probe.idx  = C_IDX;
        end
    end

    // Shift or load the entry on commit
    always_comb begin
        n_entry = r_entry;
        if (i_cmd.commit) begin
            case (i_cmd.op)
                sle_pkg::OP_INSERT: begin
                    if (C_POS == i_cmd.pos) begin
                        n_entry = i_cmd.value;
                    end else if (C_POS > i_cmd.pos) begin
                        n_entry = i_left;
                    end
                end
                sle_pkg::OP_DELETE: begin
                    if (C_POS >= i_cmd.pos) begin
                        n_entry = i_right;
                    end
                end
                default: n_entry = r_entry;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry     <= '0;
            r_probe.tok <= 1'b0;
        end else begin
            r_entry <= n_entry;
            r_probe <= n_probe;
        end
    end

    assign o_entry = r_entry;
    assign o_probe = r_probe;

endmodule

`default_nettype wire

@@ hdl/sequential_list_engine.sv @@
`default_nettype none

// Packed ordered list of up to DEPTH signed 32-bit words with insert, delete, get and locate
// operations, one result per request. The list lives in a row of DEPTH cells; each request
// sends a probe down the row, one cell per clock, and the shifts of insert and delete are
// applied to all cells at once when the probe has left the last cell. Requests are taken
// only in the idle state, so the engine holds one at a time and takes the next only once the
// last result is loaded into the output register; while an older result stalls, the next waits
// in the finish state. The store and the count clear to zero at reset with no sweep.
module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    sle_in_if.sink      i_req,
    sle_out_if.source   o_rsp
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [sle_pkg::IDX_W-1:0] C_DEPTH = sle_pkg::IDX_W'(DEPTH);

    sle_pkg::t_state                    r_state;
    sle_pkg::t_state                    n_state;
    sle_pkg::t_opcode                   r_op;
    logic [sle_pkg::POS_W-1:0]          r_pos;
    logic signed [sle_pkg::DATA_W-1:0]  r_value;
    logic [CW-1:0]                      r_count;
    sle_pkg::t_probe                    r_res;

    logic                               r_out_valid;
    logic [sle_pkg::STAT_W-1:0]         r_out_status;
    logic signed [sle_pkg::DATA_W-1:0]  r_out_data;
    logic [sle_pkg::FIDX_W-1:0]         r_out_idx;
    logic [sle_pkg::CNT_W-1:0]          r_out_count;

    logic                               w_accept;
    logic                               w_out_free;
    logic                               w_finish;
    logic [sle_pkg::IDX_W-1:0]          w_cnt;
    logic [sle_pkg::IDX_W-1:0]          w_pos;
    logic [sle_pkg::IDX_W-1:0]          w_cnt_new;
    logic [sle_pkg::STAT_W-1:0]         w_status;
    logic                               w_change;
    sle_pkg::t_cmd                      w_cmd;

    sle_pkg::t_probe                    w_probe [DEPTH:0];
    logic signed [sle_pkg::DATA_W-1:0]  w_entry [DEPTH-1:0];

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_out_free = !r_out_valid || o_rsp.ready;
    assign w_cnt      = sle_pkg::IDX_W'(r_count);
    assign w_pos      = sle_pkg::IDX_W'(r_pos);

    // Check the request against the count and the probe result
    always_comb begin
        case (r_op)
            sle_pkg::OP_INSERT: begin
                if (w_cnt == C_DEPTH) begin
                    w_status = sle_pkg::STAT_FULL;
                end else if (w_pos == '0 || w_pos > w_cnt + 1'b1) begin
                    w_status = sle_pkg::STAT_BADPOS;
                end else begin
                    w_status = sle_pkg::STAT_OK;
                end
            end
            sle_pkg::OP_DELETE,
            sle_pkg::OP_GET: begin
                if (w_cnt == '0) begin
                    w_status = sle_pkg::STAT_EMPTY;
                end else if (w_pos == '0 || w_pos > w_cnt) begin
                    w_status = sle_pkg::STAT_BADPOS;
                end else begin
                    w_status = sle_pkg::STAT_OK;
                end
            end
            default: w_status = r_res.hit ? sle_pkg::STAT_OK : sle_pkg::STAT_NOTFOUND;
        endcase
    end

    assign w_change = (w_status == sle_pkg::STAT_OK) &&
                      (r_op == sle_pkg::OP_INSERT || r_op == sle_pkg::OP_DELETE);

    // Work out the count after the operation
    always_comb begin
        w_cnt_new = w_cnt;
        if (w_change) begin
            if (r_op == sle_pkg::OP_INSERT) begin
                w_cnt_new = w_cnt + 1'b1;
            end else begin
                w_cnt_new = w_cnt - 1'b1;
            end
        end
    end

    // Sequence the request through start, scan and finish
    always_comb begin
        n_state  = r_state;
        w_finish = 1'b0;
        case (r_state)
            sle_pkg::S_IDLE:   if (w_accept) n_state = sle_pkg::S_START;
            sle_pkg::S_START:  n_state = sle_pkg::S_SCAN;
            sle_pkg::S_SCAN:   if (w_probe[DEPTH].tok) n_state = sle_pkg::S_FINISH;
            sle_pkg::S_FINISH: begin
                if (w_out_free) begin
                    w_finish = 1'b1;
                    n_state  = sle_pkg::S_IDLE;
                end
            end
            default: n_state = sle_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Broadcast the command to the cells
    assign w_cmd.commit = w_finish && w_change;
    assign w_cmd.op     = r_op;
    assign w_cmd.pos    = w_pos;
    assign w_cmd.count  = w_cnt;
    assign w_cmd.value  = r_value;

    // Inject the probe in the start state, in the cycle after acceptance
    assign w_probe[0].tok  = (r_state == sle_pkg::S_START);
    assign w_probe[0].hit  = 1'b0;
    assign w_probe[0].data = '0;
    assign w_probe[0].idx  = '0;

    // Row of cells
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic signed [sle_pkg::DATA_W-1:0] w_left;
        logic signed [sle_pkg::DATA_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right = '0;
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        sle_cell #(
            .INDEX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd),
            .i_left  (w_left),
            .i_right (w_right),
            .i_probe (w_probe[g]),
            .o_entry (w_entry[g]),
            .o_probe (w_probe[g+1])
        );
    end

    // Hold the request payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op    <= sle_pkg::t_opcode'(i_req.opcode);
            r_pos   <= i_req.position;
            r_value <= i_req.value;
        end
    end

    // Capture the probe as it leaves the last cell
    always_ff @(posedge i_clk) begin
        if (r_state == sle_pkg::S_SCAN && w_probe[DEPTH].tok) begin
            r_res <= w_probe[DEPTH];
        end
    end

    // Update the entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (w_finish) begin
            r_count <= CW'(w_cnt_new);
        end
    end

    // Output register: load on finish, drop on transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out_status <= w_status;
            r_out_count  <= w_cnt_new[sle_pkg::CNT_W-1:0];
            if (w_status == sle_pkg::STAT_OK &&
                (r_op == sle_pkg::OP_GET || r_op == sle_pkg::OP_DELETE)) begin
                r_out_data <= r_res.data;
            end else begin
                r_out_data <= '0;
            end
            if (w_status == sle_pkg::STAT_OK && r_op == sle_pkg::OP_LOCATE) begin
                r_out_idx <= r_res.idx[sle_pkg::FIDX_W-1:0];
            end else begin
                r_out_idx <= '0;
            end
        end
    end

    assign i_req.ready       = (r_state == sle_pkg::S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.data_out    = r_out_data;
    assign o_rsp.found_index = r_out_idx;
    assign o_rsp.count       = r_out_count;

endmodule

`default_nettype wire

@@ hdl/sle_checker.sv @@
`default_nettype none

module sle_checker #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input wire                                      i_clk,
    input wire                                      i_rst_n,
    input wire                                      i_req_valid,
    input wire                                      i_req_ready,
    input wire                                      i_rsp_valid,
    input wire                                      i_rsp_ready,
    input wire logic [sle_pkg::STAT_W-1:0]          i_rsp_status,
    input wire logic signed [sle_pkg::DATA_W-1:0]   i_rsp_data_out,
    input wire logic [sle_pkg::FIDX_W-1:0]          i_rsp_found_index,
    input wire logic [sle_pkg::CNT_W-1:0]           i_rsp_count
);

    // A stalled result holds its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=>
            (i_rsp_valid && $stable(i_rsp_status) && $stable(i_rsp_data_out) &&
             $stable(i_rsp_found_index) && $stable(i_rsp_count)))
        else $error("result changed while stalled");

    // One request in flight: no request is taken in the cycle after a transaction
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |=> !i_req_ready)
        else $error("request taken while another is in flight");

    // A failed operation returns no data and no index
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status != sle_pkg::STAT_OK) |->
            (i_rsp_data_out == '0 && i_rsp_found_index == '0))
        else $error("failed operation returned data");

    // A full refusal reports a full list
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && i_rsp_status == sle_pkg::STAT_FULL) |->
            (i_rsp_count == sle_pkg::CNT_W'(DEPTH)))
        else $error("full status with count below depth");

endmodule

bind sequential_list_engine sle_checker #(
    .DEPTH (DEPTH)
) u_sle_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_req_valid       (i_req.valid),
    .i_req_ready       (i_req.ready),
    .i_rsp_valid       (o_rsp.valid),
    .i_rsp_ready       (o_rsp.ready),
    .i_rsp_status      (o_rsp.status),
    .i_rsp_data_out    (o_rsp.data_out),
    .i_rsp_found_index (o_rsp.found_index),
    .i_rsp_count       (o_rsp.count)
);

`default_nettype wire
